[rtl/nack_selective_repeat_engine_core_defines.svh]
`ifndef NACK_SELECTIVE_REPEAT_ENGINE_CORE_DEFINES_SVH
`define NACK_SELECTIVE_REPEAT_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NSR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nsr assertion failed");

// Next-cycle implication, checked outside reset.
`define NSR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nsr assertion failed");

`endif

[rtl/nsr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package nsr_pkg;

  localparam int PEER_COUNT  = 16;
  localparam int WINDOW      = 16;
  localparam int TAG_BITS    = 16;
  localparam int MAX_RESULTS = 16;
  localparam int SEQ_BITS    = 32;
  localparam int PEER_BITS   = $clog2(PEER_COUNT);
  localparam int WIN_BITS    = $clog2(WINDOW);
  localparam int SLOT_BITS   = PEER_BITS + WIN_BITS;
  localparam int SLOTS       = PEER_COUNT * WINDOW;
  localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);

  // Input modes.
  localparam logic [1:0] MODE_SEND = 2'd0;
  localparam logic [1:0] MODE_DATA = 2'd1;
  localparam logic [1:0] MODE_NACK = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_NACK  = 2'd1;
  localparam logic [1:0] KIND_DELIV = 2'd2;
  localparam logic [1:0] KIND_DROP  = 2'd3;

  typedef struct packed {
    logic [1:0]           mode;
    logic [PEER_BITS-1:0] peer;
    logic [SEQ_BITS-1:0]  seq_in;
    logic [SEQ_BITS-1:0]  ack_in;
    logic [TAG_BITS-1:0]  tag_in;
  } item_t;

  // Queue head seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [PEER_BITS-1:0] peer_out;
    logic [7:0]           source_out;
    logic [SEQ_BITS-1:0]  seq_out;
    logic [SEQ_BITS-1:0]  ack_out;
    logic [TAG_BITS-1:0]  tag_out;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic [SEQ_BITS-1:0] seq;
    logic [SEQ_BITS-1:0] ack;
    logic [TAG_BITS-1:0] tag;
  } send_ent_t;

endpackage
`default_nettype wire

[rtl/nsr_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none
// Input word channel.
interface nsr_in_if import nsr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [PEER_BITS-1:0] peer;
  logic [SEQ_BITS-1:0]  seq_in;
  logic [SEQ_BITS-1:0]  ack_in;
  logic [TAG_BITS-1:0]  tag_in;
  modport source (output valid, mode, peer, seq_in, ack_in, tag_in, input ready);
  modport sink   (input valid, mode, peer, seq_in, ack_in, tag_in, output ready);
endinterface

// Result word channel.
interface nsr_out_if import nsr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           kind;
  logic [PEER_BITS-1:0] peer_out;
  logic [7:0]           source_out;
  logic [SEQ_BITS-1:0]  seq_out;
  logic [SEQ_BITS-1:0]  ack_out;
  logic [TAG_BITS-1:0]  tag_out;
  logic                 last;
  modport source (output valid, kind, peer_out, source_out, seq_out, ack_out, tag_out,
                  last, input ready);
  modport sink   (input valid, kind, peer_out, source_out, seq_out, ack_out, tag_out,
                  last, output ready);
endinterface

// Configuration write channel.
interface nsr_cfg_if import nsr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] own_address;
  modport source (output valid, own_address, input ready);
  modport sink   (input valid, own_address, output ready);
endinterface
`default_nettype wire

[rtl/nsr_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module nsr_front import nsr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  nsr_in_if.sink    in_ch,
  output qhead_t    q_head,
  input  wire logic q_pop
);

  item_t      ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  item_t      in_item;

  // Gather the incoming word; unused mode codes are taken and discarded.
  always_comb begin
    in_item.mode   = in_ch.mode;
    in_item.peer   = in_ch.peer;
    in_item.seq_in = in_ch.seq_in;
    in_item.ack_in = in_ch.ack_in;
    in_item.tag_in = in_ch.tag_in;
  end

  assign in_ch.ready  = (cnt_r != 2'd2);
  assign push         = in_ch.valid && in_ch.ready && (in_ch.mode != MODE_NONE);
  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.item  = ent_r[rp_r];

  // Two-entry queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  // Queue payload.
  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= in_item;
  end

endmodule
`default_nettype wire

[rtl/nsr_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "nack_selective_repeat_engine_core_defines.svh"
module nsr_engine import nsr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] own_address,
  input  wire qhead_t     q_head,
  output logic            q_pop,
  nsr_out_if.source       out_ch
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SEND     = 4'd1;
  localparam logic [3:0] S_ACK_RD   = 4'd2;
  localparam logic [3:0] S_ACK_CHK  = 4'd3;
  localparam logic [3:0] S_SWEEP    = 4'd4;
  localparam logic [3:0] S_POST     = 4'd5;
  localparam logic [3:0] S_NACK_CHK = 4'd6;
  localparam logic [3:0] S_DELIV    = 4'd7;
  localparam logic [3:0] S_CH_RD    = 4'd8;
  localparam logic [3:0] S_CH_EM    = 4'd9;
  localparam logic [3:0] S_GAP      = 4'd10;

  localparam logic [WIN_BITS:0]  SW_END   = (WIN_BITS + 1)'(WINDOW);
  localparam logic [SEQ_BITS-1:0] SEQ_MAX = '1;

  logic [3:0]          state_r, state_nxt;
  item_t               item_r, item_nxt;
  logic [SEQ_BITS-1:0] d_r, d_nxt;
  logic [CNT_BITS-1:0] n_r, n_nxt;
  logic [WIN_BITS:0]   sw_cnt_r, sw_cnt_nxt;
  logic [WINDOW-1:0]   mask_r, mask_nxt;
  res_t                out_r, out_nxt;
  logic                out_valid_r;

  logic [SEQ_BITS-1:0] nss_r  [PEER_COUNT];
  logic [SEQ_BITS-1:0] dseq_r [PEER_COUNT];
  logic [SLOTS-1:0]    send_valid_r, recv_valid_r;
  send_ent_t           send_mem [SLOTS];
  logic [TAG_BITS-1:0] recv_mem [SLOTS];
  send_ent_t           send_rd_r;
  logic [TAG_BITS-1:0] recv_rd_r;

  // Control strobes.
  logic                 can_load, out_load;
  logic                 send_wr_en, send_rd_en, recv_wr_en, recv_rd_en;
  logic [SLOT_BITS-1:0] send_wr_addr, send_rd_addr, recv_wr_addr, recv_rd_addr;
  send_ent_t            send_wr_data;
  logic                 sv_set, sv_clr, rv_clr;
  logic [SLOT_BITS-1:0] sv_clr_addr, rv_clr_addr;
  logic                 nss_we, dseq_we;
  logic [SEQ_BITS-1:0]  nss_val, dseq_val;

  // Working values for the current word.
  logic [PEER_BITS-1:0] p;
  logic [SEQ_BITS-1:0]  cur_d, diff, ns, dn;
  logic [SLOT_BITS-1:0] seq_slot, ack_slot;
  logic [WIN_BITS:0]    sw_prev;
  logic [WINDOW-1:0]    gap_mask, rem_mask;
  logic [WIN_BITS-1:0]  top;
  logic                 more;

  function automatic logic [SLOT_BITS-1:0] slot_of(input logic [PEER_BITS-1:0] pp,
                                                   input logic [SEQ_BITS-1:0] s);
    slot_of = {pp, s[WIN_BITS-1:0]};
  endfunction

  function automatic logic [WIN_BITS-1:0] highest(input logic [WINDOW-1:0] m);
    logic [WIN_BITS-1:0] h;
    h = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (m[i]) h = WIN_BITS'(i);
    end
    highest = h;
  endfunction

  assign p        = item_r.peer;
  assign cur_d    = dseq_r[p];
  assign diff     = item_r.seq_in - cur_d;
  assign ns       = nss_r[p] + 1'b1;
  assign dn       = d_r + 1'b1;
  assign seq_slot = slot_of(p, item_r.seq_in);
  assign ack_slot = slot_of(p, item_r.ack_in);
  assign sw_prev  = sw_cnt_r - 1'b1;
  assign can_load = !out_valid_r || out_ch.ready;
  assign top      = highest(mask_r);
  assign rem_mask = mask_r & ~(WINDOW'(1) << top);

  // Missing sequences above the delivered one that are not yet buffered.
  always_comb begin
    for (int j = 0; j < WINDOW; j++) begin
      gap_mask[j] = (j != 0) && ((WIN_BITS + 1)'(j) < diff[WIN_BITS:0]) &&
                    !recv_valid_r[slot_of(p, cur_d + SEQ_BITS'(j))];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    d_nxt        = d_r;
    n_nxt        = n_r;
    sw_cnt_nxt   = sw_cnt_r;
    mask_nxt     = mask_r;
    q_pop        = 1'b0;
    out_load     = 1'b0;
    out_nxt      = out_r;
    send_wr_en   = 1'b0;
    send_wr_addr = seq_slot;
    send_wr_data = '{seq: ns, ack: cur_d, tag: item_r.tag_in};
    send_rd_en   = 1'b0;
    send_rd_addr = ack_slot;
    recv_wr_en   = 1'b0;
    recv_wr_addr = seq_slot;
    recv_rd_en   = 1'b0;
    recv_rd_addr = slot_of(p, dn);
    sv_set       = 1'b0;
    sv_clr       = 1'b0;
    sv_clr_addr  = slot_of(p, SEQ_BITS'(sw_prev[WIN_BITS-1:0]));
    rv_clr       = 1'b0;
    rv_clr_addr  = slot_of(p, dn);
    nss_we       = 1'b0;
    nss_val      = ns;
    dseq_we      = 1'b0;
    dseq_val     = d_r;
    more         = 1'b0;

    out_nxt.peer_out   = p;
    out_nxt.source_out = own_address;

    unique case (state_r)
      S_IDLE: begin
        if (q_head.valid) begin
          q_pop     = 1'b1;
          item_nxt  = q_head.item;
          state_nxt = (q_head.item.mode == MODE_SEND) ? S_SEND : S_ACK_RD;
        end
      end
      // New send: take the next number, cache it and emit the data word.
      S_SEND: begin
        if (can_load) begin
          send_wr_en      = 1'b1;
          send_wr_addr    = slot_of(p, ns);
          sv_set          = 1'b1;
          nss_we          = 1'b1;
          out_load        = 1'b1;
          out_nxt.kind    = KIND_DATA;
          out_nxt.seq_out = ns;
          out_nxt.ack_out = cur_d;
          out_nxt.tag_out = item_r.tag_in;
          out_nxt.last    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_ACK_RD: begin
        send_rd_en = 1'b1;
        state_nxt  = S_ACK_CHK;
      end
      // Release the window only when the acked number is itself cached.
      S_ACK_CHK: begin
        sw_cnt_nxt = '0;
        if (send_valid_r[ack_slot] && (send_rd_r.seq == item_r.ack_in)) begin
          state_nxt = S_SWEEP;
        end else begin
          state_nxt = S_POST;
        end
      end
      // Read one entry per cycle and compare the one read the cycle before.
      S_SWEEP: begin
        if (sw_cnt_r != SW_END) begin
          send_rd_en   = 1'b1;
          send_rd_addr = slot_of(p, SEQ_BITS'(sw_cnt_r[WIN_BITS-1:0]));
        end
        if (sw_cnt_r != '0) begin
          if (send_valid_r[sv_clr_addr] && (send_rd_r.seq <= item_r.ack_in)) begin
            sv_clr = 1'b1;
          end
        end
        sw_cnt_nxt = sw_cnt_r + 1'b1;
        if (sw_cnt_r == SW_END) state_nxt = S_POST;
      end
      S_POST: begin
        if (item_r.mode == MODE_NACK) begin
          send_rd_en   = 1'b1;
          send_rd_addr = seq_slot;
          state_nxt    = S_NACK_CHK;
        end else if (item_r.seq_in <= cur_d) begin
          state_nxt = S_IDLE;
        end else if (diff == SEQ_BITS'(1)) begin
          state_nxt = S_DELIV;
        end else if (diff > SEQ_BITS'(WINDOW)) begin
          if (can_load) begin
            out_load        = 1'b1;
            out_nxt.kind    = KIND_DROP;
            out_nxt.seq_out = item_r.seq_in;
            out_nxt.ack_out = '0;
            out_nxt.tag_out = item_r.tag_in;
            out_nxt.last    = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else begin
          mask_nxt  = gap_mask;
          state_nxt = S_GAP;
        end
      end
      // Resend the requested entry if it is still cached.
      S_NACK_CHK: begin
        if (send_valid_r[seq_slot] && (send_rd_r.seq == item_r.seq_in)) begin
          if (can_load) begin
            out_load        = 1'b1;
            out_nxt.kind    = KIND_DATA;
            out_nxt.seq_out = send_rd_r.seq;
            out_nxt.ack_out = send_rd_r.ack;
            out_nxt.tag_out = send_rd_r.tag;
            out_nxt.last    = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      // In-order arrival: deliver it, then look for buffered successors.
      S_DELIV: begin
        more = (item_r.seq_in != SEQ_MAX) &&
               recv_valid_r[slot_of(p, item_r.seq_in + 1'b1)] && (MAX_RESULTS > 1);
        if (can_load) begin
          out_load        = 1'b1;
          out_nxt.kind    = KIND_DELIV;
          out_nxt.seq_out = item_r.seq_in;
          out_nxt.ack_out = '0;
          out_nxt.tag_out = item_r.tag_in;
          out_nxt.last    = !more;
          d_nxt           = item_r.seq_in;
          n_nxt           = CNT_BITS'(1);
          if (more) begin
            state_nxt = S_CH_RD;
          end else begin
            dseq_we   = 1'b1;
            dseq_val  = item_r.seq_in;
            state_nxt = S_IDLE;
          end
        end
      end
      S_CH_RD: begin
        recv_rd_en = 1'b1;
        state_nxt  = S_CH_EM;
      end
      S_CH_EM: begin
        more = (dn != SEQ_MAX) && recv_valid_r[slot_of(p, dn + 1'b1)] &&
               ((n_r + 1'b1) < CNT_BITS'(MAX_RESULTS));
        if (can_load) begin
          out_load        = 1'b1;
          out_nxt.kind    = KIND_DELIV;
          out_nxt.seq_out = dn;
          out_nxt.ack_out = '0;
          out_nxt.tag_out = recv_rd_r;
          out_nxt.last    = !more;
          rv_clr          = 1'b1;
          d_nxt           = dn;
          n_nxt           = n_r + 1'b1;
          if (more) begin
            state_nxt = S_CH_RD;
          end else begin
            dseq_we   = 1'b1;
            dseq_val  = dn;
            state_nxt = S_IDLE;
          end
        end
      end
      // Gap: NACK missing numbers from the highest down, then buffer the word.
      S_GAP: begin
        if (mask_r == '0) begin
          recv_wr_en = !recv_valid_r[seq_slot];
          state_nxt  = S_IDLE;
        end else if (can_load) begin
          out_load        = 1'b1;
          out_nxt.kind    = KIND_NACK;
          out_nxt.seq_out = cur_d + SEQ_BITS'(top);
          out_nxt.ack_out = cur_d;
          out_nxt.tag_out = '0;
          out_nxt.last    = (rem_mask == '0);
          mask_nxt        = rem_mask;
          if (rem_mask == '0) begin
            recv_wr_en = !recv_valid_r[seq_slot];
            state_nxt  = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers, per-peer counters and valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      send_valid_r <= '0;
      recv_valid_r <= '0;
      sw_cnt_r     <= '0;
      n_r          <= '0;
      for (int i = 0; i < PEER_COUNT; i++) begin
        nss_r[i]  <= '0;
        dseq_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      sw_cnt_r <= sw_cnt_nxt;
      n_r      <= n_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (sv_set) send_valid_r[send_wr_addr] <= 1'b1;
      if (sv_clr) send_valid_r[sv_clr_addr] <= 1'b0;
      if (recv_wr_en) recv_valid_r[recv_wr_addr] <= 1'b1;
      if (rv_clr) recv_valid_r[rv_clr_addr] <= 1'b0;
      if (nss_we) nss_r[p] <= nss_val;
      if (dseq_we) dseq_r[p] <= dseq_val;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    d_r    <= d_nxt;
    mask_r <= mask_nxt;
    if (out_load) out_r <= out_nxt;
  end

  // Send window memory.
  always_ff @(posedge clk) begin
    if (send_wr_en) send_mem[send_wr_addr] <= send_wr_data;
    if (send_rd_en) send_rd_r <= send_mem[send_rd_addr];
  end

  // Receive buffer memory.
  always_ff @(posedge clk) begin
    if (recv_wr_en) recv_mem[recv_wr_addr] <= item_r.tag_in;
    if (recv_rd_en) recv_rd_r <= recv_mem[recv_rd_addr];
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_r.kind;
  assign out_ch.peer_out   = out_r.peer_out;
  assign out_ch.source_out = out_r.source_out;
  assign out_ch.seq_out    = out_r.seq_out;
  assign out_ch.ack_out    = out_r.ack_out;
  assign out_ch.tag_out    = out_r.tag_out;
  assign out_ch.last       = out_r.last;

  `NSR_ASSERT_IMP(a_pop_only_idle, q_pop, state_r == S_IDLE)
  `NSR_ASSERT_IMP(a_no_result_idle, state_r == S_IDLE, !out_load)
  `NSR_ASSERT_NXT(a_sweep_ends, (state_r == S_SWEEP) && (sw_cnt_r == SW_END), state_r == S_POST)
  `NSR_ASSERT_IMP(a_gap_no_self, state_r == S_GAP, !mask_r[0])

endmodule
`default_nettype wire

[rtl/nack_selective_repeat_engine_core.sv]
// A send request leaves the input queue in S_IDLE; S_SEND loads its data word into the
// output register. A data or NACK arrival reads the ack entry (S_ACK_RD, S_ACK_CHK) and,
// when the ack is cached, sweeps the send window through its single read port (S_SWEEP).
// Successors then go out (S_CH_RD, S_CH_EM), or NACKs (S_GAP); words run one at a time.
// Reset (rst_n low, synchronous) clears counters, valid bits, queue and own_address;
// the slot memories are not cleared and are only read behind a valid bit.
`timescale 1ns / 1ps
`default_nettype none
module nack_selective_repeat_engine_core import nsr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  nsr_in_if.sink    in_ch,
  nsr_out_if.source out_ch,
  nsr_cfg_if.sink   cfg_ch
);

  logic [7:0] own_address_r;
  qhead_t     q_head;
  logic       q_pop;

  // Configuration register, writable at any time.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= '0;
    end else if (cfg_ch.valid) begin
      own_address_r <= cfg_ch.own_address;
    end
  end

  nsr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  nsr_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .own_address (own_address_r),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps
module tb;
  import nsr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;

  // Shadow of the ARQ engine: per-peer counters, send and receive windows,
  // and the words the engine is expected to emit, oldest first.
  class arq_scoreboard;
    logic [7:0]          own_addr;
    logic [SEQ_BITS-1:0] next_seq [PEER_COUNT];
    logic [SEQ_BITS-1:0] deliv_seq [PEER_COUNT];
    bit                  tx_valid [SLOTS];
    logic [SEQ_BITS-1:0] tx_seq [SLOTS];
    logic [SEQ_BITS-1:0] tx_ack [SLOTS];
    logic [TAG_BITS-1:0] tx_tag [SLOTS];
    bit                  rx_valid [SLOTS];
    logic [TAG_BITS-1:0] rx_tag [SLOTS];
    res_t                pending_words [$];
    res_t                step_words [$];
    bit                  failed;

    function new();
      own_addr = '0;
      failed = 0;
      foreach (next_seq[i]) begin
        next_seq[i] = '0;
        deliv_seq[i] = '0;
      end
      foreach (tx_valid[i]) begin
        tx_valid[i] = 0;
        rx_valid[i] = 0;
      end
    endfunction

    function int slot(int p, logic [SEQ_BITS-1:0] sq);
      return p * WINDOW + int'(sq % WINDOW);
    endfunction

    function void push_word(logic [1:0] k, int p, logic [SEQ_BITS-1:0] sq,
                            logic [SEQ_BITS-1:0] ak, logic [TAG_BITS-1:0] tg);
      res_t r;
      if (step_words.size() >= MAX_RESULTS) return;
      r.kind = k;
      r.peer_out = p[PEER_BITS-1:0];
      r.source_out = own_addr;
      r.seq_out = sq;
      r.ack_out = ak;
      r.tag_out = tg;
      r.last = 1'b0;
      step_words.push_back(r);
    endfunction

    // Release every cached send entry up to the ack, only when the ack is cached.
    function void release_acked(int p, logic [SEQ_BITS-1:0] ak);
      int s;
      s = slot(p, ak);
      if (!tx_valid[s] || tx_seq[s] != ak) return;
      for (int i = 0; i < WINDOW; i++) begin
        if (tx_valid[p*WINDOW+i] && tx_seq[p*WINDOW+i] <= ak) tx_valid[p*WINDOW+i] = 0;
      end
    endfunction

    // Work out the words caused by one accepted input word.
    function void note_word(item_t it);
      int p;
      int s;
      logic [SEQ_BITS-1:0] d;
      logic [SEQ_BITS-1:0] ns;
      logic [SEQ_BITS-1:0] m;
      logic [SEQ_BITS-1:0] missing;
      step_words.delete();
      p = int'(it.peer);
      if (it.mode == MODE_SEND) begin
        ns = next_seq[p] + 1;
        next_seq[p] = ns;
        s = slot(p, ns);
        tx_valid[s] = 1;
        tx_seq[s] = ns;
        tx_ack[s] = deliv_seq[p];
        tx_tag[s] = it.tag_in;
        push_word(KIND_DATA, p, ns, deliv_seq[p], it.tag_in);
      end else if (it.mode == MODE_NACK) begin
        release_acked(p, it.ack_in);
        s = slot(p, it.seq_in);
        if (tx_valid[s] && tx_seq[s] == it.seq_in)
          push_word(KIND_DATA, p, tx_seq[s], tx_ack[s], tx_tag[s]);
      end else if (it.mode == MODE_DATA) begin
        release_acked(p, it.ack_in);
        d = deliv_seq[p];
        if (d >= it.seq_in) begin
          // Duplicate: nothing comes out.
        end else if (it.seq_in - d == 1) begin
          push_word(KIND_DELIV, p, it.seq_in, '0, it.tag_in);
          d = it.seq_in;
          while (d != '1 && step_words.size() < MAX_RESULTS) begin
            s = slot(p, d + 1);
            if (!rx_valid[s]) break;
            push_word(KIND_DELIV, p, d + 1, '0, rx_tag[s]);
            rx_valid[s] = 0;
            d = d + 1;
          end
          deliv_seq[p] = d;
        end else if (it.seq_in - d > WINDOW) begin
          push_word(KIND_DROP, p, it.seq_in, '0, it.tag_in);
        end else begin
          // Gap: NACK each missing sequence not yet buffered, highest first.
          missing = it.seq_in - d - 1;
          for (int i = 0; i < int'(missing); i++) begin
            m = it.seq_in - 1 - i;
            if (!rx_valid[slot(p, m)]) push_word(KIND_NACK, p, m, d, '0);
          end
          s = slot(p, it.seq_in);
          if (!rx_valid[s]) begin
            rx_valid[s] = 1;
            rx_tag[s] = it.tag_in;
          end
        end
      end
      if (step_words.size() > 0) step_words[step_words.size()-1].last = 1'b1;
      foreach (step_words[i]) pending_words.push_back(step_words[i]);
    endfunction

    function void check_word(res_t got);
      res_t w;
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected: kind %0d seq %0h", got.kind, got.seq_out);
        failed = 1;
        return;
      end
      w = pending_words.pop_front();
      if (got.kind != w.kind) begin
        $error("kind: expected %0d, got %0d", w.kind, got.kind); failed = 1;
      end
      if (got.peer_out != w.peer_out) begin
        $error("peer_out: expected %0d, got %0d", w.peer_out, got.peer_out); failed = 1;
      end
      if (got.source_out != w.source_out) begin
        $error("source_out: expected %0h, got %0h", w.source_out, got.source_out); failed = 1;
      end
      if (got.seq_out != w.seq_out) begin
        $error("seq_out: expected %0h, got %0h", w.seq_out, got.seq_out); failed = 1;
      end
      if (got.ack_out != w.ack_out) begin
        $error("ack_out: expected %0h, got %0h", w.ack_out, got.ack_out); failed = 1;
      end
      if (got.tag_out != w.tag_out) begin
        $error("tag_out: expected %0h, got %0h", w.tag_out, got.tag_out); failed = 1;
      end
      if (got.last != w.last) begin
        $error("last: expected %0d, got %0d", w.last, got.last); failed = 1;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  nsr_in_if  in_ch ();
  nsr_out_if out_ch ();
  nsr_cfg_if cfg_ch ();

  nack_selective_repeat_engine_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  arq_scoreboard sb;
  int in_idle_pct;
  int out_idle_pct;
  int hold_cycles;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready = 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      res_t r;
      r.kind = out_ch.kind;
      r.peer_out = out_ch.peer_out;
      r.source_out = out_ch.source_out;
      r.seq_out = out_ch.seq_out;
      r.ack_out = out_ch.ack_out;
      r.tag_out = out_ch.tag_out;
      r.last = out_ch.last;
      sb.check_word(r);
    end
  end

  // Offer one word and hold it until the engine takes it.
  task automatic send_word(item_t it);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.mode = it.mode;
    in_ch.peer = it.peer;
    in_ch.seq_in = it.seq_in;
    in_ch.ack_in = it.ack_in;
    in_ch.tag_in = it.tag_in;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(it);
    @(negedge clk);
  endtask

  task automatic word(logic [1:0] md, int p, logic [31:0] sq, logic [31:0] ak,
                      logic [15:0] tg);
    item_t it;
    it.mode = md;
    it.peer = p[PEER_BITS-1:0];
    it.seq_in = sq;
    it.ack_in = ak;
    it.tag_in = tg;
    send_word(it);
  endtask

  // Write the address register once the engine has gone quiet.
  task automatic write_address(logic [7:0] a);
    in_ch.valid = 1'b0;
    while (sb.pending_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_ch.own_address = a;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.own_addr = a;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Mostly well-formed traffic around each peer's live windows, some noise.
  task automatic random_word();
    int r;
    int p;
    logic [31:0] sq;
    logic [31:0] ak;
    logic [1:0] md;
    r = $urandom_range(0, 99);
    p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
    ak = ($urandom_range(0, 1) == 1) ? sb.next_seq[p] - $urandom_range(0, WINDOW - 1)
                                     : $urandom;
    if (r < 33) begin
      md = MODE_SEND;
      sq = $urandom;
    end else if (r < 75) begin
      md = MODE_DATA;
      case ($urandom_range(0, 9))
        0: sq = sb.deliv_seq[p] - $urandom_range(0, 3);
        1: sq = $urandom;
        default: sq = sb.deliv_seq[p] + $urandom_range(1, WINDOW + 1);
      endcase
    end else if (r < 92) begin
      md = MODE_NACK;
      sq = sb.next_seq[p] - $urandom_range(0, 20);
    end else begin
      md = 2'($urandom_range(0, 3));
      sq = $urandom;
    end
    word(md, p, sq, ak, 16'($urandom));
  endtask

  task automatic directed_words();
    word(MODE_SEND, 0, 0, 0, 16'hFFFF);
    word(MODE_SEND, 0, 0, 0, 16'h0001);
    word(MODE_SEND, 15, 0, 0, 16'h8000);
    // Gap: NACKs for 2 and 1, then 3 is buffered; repeating it NACKs 2 and 1 again and keeps the buffered tag.
    word(MODE_DATA, 0, 3, 0, 16'h0033);
    word(MODE_DATA, 0, 3, 0, 16'h0034);
    word(MODE_DATA, 0, 2, 0, 16'h0022);
    // In-order arrival releases the buffered successors.
    word(MODE_DATA, 0, 1, 0, 16'h0011);
    word(MODE_DATA, 0, 2, 0, 16'h0000);
    word(MODE_DATA, 0, 100, 0, 16'hABCD);
    word(MODE_DATA, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    word(MODE_DATA, 15, 17, 0, 16'h1717);
    word(MODE_DATA, 15, 16, 0, 16'h1616);
    // NACK resend, then an ack that frees the send entries up to it.
    word(MODE_NACK, 0, 2, 0, 16'h0000);
    word(MODE_NACK, 0, 1, 1, 16'h0000);
    word(MODE_NACK, 0, 1, 1, 16'h0000);
    word(MODE_NACK, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    word(MODE_NONE, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    for (int i = 0; i < 18; i++) word(MODE_SEND, 1, 0, 0, i[15:0]);
    word(MODE_NACK, 1, 18, 0, 16'h0000);
    word(MODE_NACK, 1, 2, 0, 16'h0000);
  endtask

  initial begin
    sb = new();
    cycle_count = 0;
    hold_cycles = 0;
    in_idle_pct = 13;
    out_idle_pct = 55;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_SEND;
    in_ch.peer = '0;
    in_ch.seq_in = '0;
    in_ch.ack_in = '0;
    in_ch.tag_in = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.own_address = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Phase one: directed words at the reset address, then random traffic.
    directed_words();
    for (int i = 0; i < 160; i++) begin
      if (i == 60) hold_cycles = 400;
      random_word();
    end

    // Phase two: sender idles more than the receiver.
    write_address(8'hFF);
    in_idle_pct = 55;
    out_idle_pct = 13;
    for (int i = 0; i < 160; i++) random_word();

    // Phase three: no idling at all.
    write_address(8'($urandom_range(1, 254)));
    in_idle_pct = 0;
    out_idle_pct = 0;
    for (int i = 0; i < 80; i++) random_word();
    write_address(8'h00);
    for (int i = 0; i < 80; i++) random_word();

    in_ch.valid = 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!sb.failed && sb.pending_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
